### rtl/kra_pkg.sv
// Shared constants, types and write-port structs for the keyed registry with lease aging.
package kra_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_BITS    = 48;
  localparam int LEASE_W     = 16;
  localparam int WANT_W      = 8;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int CMP_W       = (CNT_W > WANT_W) ? CNT_W : WANT_W;
  localparam int LEASE_RESET = 30;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_WITHDRAW = 2'd1,
    OP_LIST     = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    addr;
    logic [KEY_BITS-1:0] data;
  } key_wr_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [LEASE_W-1:0] data;
  } lease_wr_t;

endpackage

### rtl/kra_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module kra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/kra_seq.sv
// Slot sequencer: scans the key and lease memories one slot per cycle for every item.
module kra_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [kra_pkg::KEY_BITS-1:0]  source_key,
  input  logic [kra_pkg::WANT_W-1:0]    list_count,
  input  logic                          cfg_we,
  input  logic [kra_pkg::LEASE_W-1:0]   cfg_data,
  output logic [kra_pkg::IDX_W-1:0]     rd_addr,
  input  logic [kra_pkg::KEY_BITS-1:0]  key_rd,
  input  logic [kra_pkg::LEASE_W-1:0]   lease_rd,
  output kra_pkg::key_wr_t              key_wr,
  output kra_pkg::lease_wr_t            lease_wr,
  output logic                          out_strobe,
  output logic [kra_pkg::KEY_BITS-1:0]  out_entry_key,
  output logic                          out_last_entry
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                         state_r, state_nxt;
  kra_pkg::op_t                   op_r, op_nxt;
  logic [kra_pkg::KEY_BITS-1:0]   key_r, key_nxt;
  logic [kra_pkg::CNT_W-1:0]      n_r, n_nxt;
  logic [kra_pkg::CNT_W-1:0]      issue_r, issue_nxt;
  logic                           pv_r, pv_nxt;
  logic [kra_pkg::IDX_W-1:0]      pidx_r, pidx_nxt;
  logic                           match_r, match_nxt;
  logic [kra_pkg::IDX_W-1:0]      match_idx_r, match_idx_nxt;
  logic                           free_r, free_nxt;
  logic [kra_pkg::IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic [kra_pkg::CNT_W-1:0]      produced_r, produced_nxt;
  logic [kra_pkg::ENTRIES-1:0]    valid_r, valid_nxt;
  logic [kra_pkg::CNT_W-1:0]      active_r, active_nxt;
  logic [kra_pkg::LEASE_W-1:0]    lease_cfg_r, lease_cfg_nxt;
  logic                           strobe_r, strobe_nxt;
  logic [kra_pkg::KEY_BITS-1:0]   okey_r, okey_nxt;
  logic                           olast_r, olast_nxt;

  logic                           issuing;
  logic                           hit;
  logic [kra_pkg::CMP_W-1:0]      want_ext;
  logic [kra_pkg::CMP_W-1:0]      active_ext;

  assign issuing    = issue_r < kra_pkg::CNT_W'(kra_pkg::ENTRIES);
  assign rd_addr    = issue_r[kra_pkg::IDX_W-1:0];
  assign hit        = pv_r && valid_r[pidx_r] && (key_rd == key_r);
  assign want_ext   = kra_pkg::CMP_W'(list_count);
  assign active_ext = kra_pkg::CMP_W'(active_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    n_nxt         = n_r;
    issue_nxt     = issue_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    produced_nxt  = produced_r;
    valid_nxt     = valid_r;
    active_nxt    = active_r;
    lease_cfg_nxt = cfg_we ? cfg_data : lease_cfg_r;
    strobe_nxt    = 1'b0;
    okey_nxt      = okey_r;
    olast_nxt     = 1'b0;
    key_wr        = '0;
    lease_wr      = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt    = ST_SCAN;
          op_nxt       = kra_pkg::op_t'(opcode);
          key_nxt      = source_key;
          n_nxt        = (want_ext > active_ext) ? active_r : kra_pkg::CNT_W'(list_count);
          issue_nxt    = '0;
          match_nxt    = 1'b0;
          free_nxt     = 1'b0;
          produced_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          pv_nxt    = 1'b1;
          pidx_nxt  = issue_r[kra_pkg::IDX_W-1:0];
          issue_nxt = issue_r + kra_pkg::CNT_W'(1);
        end
        if (pv_r) begin
          case (op_r)
            kra_pkg::OP_REGISTER: begin
              if (hit && !match_r) begin
                match_nxt     = 1'b1;
                match_idx_nxt = pidx_r;
              end
              if (!valid_r[pidx_r] && !free_r) begin
                free_nxt     = 1'b1;
                free_idx_nxt = pidx_r;
              end
            end
            kra_pkg::OP_WITHDRAW: begin
              if (hit && !match_r) begin
                match_nxt         = 1'b1;
                valid_nxt[pidx_r] = 1'b0;
                active_nxt        = active_r - kra_pkg::CNT_W'(1);
              end
            end
            kra_pkg::OP_LIST: begin
              if (valid_r[pidx_r] && (produced_r < n_r)) begin
                strobe_nxt   = 1'b1;
                okey_nxt     = key_rd;
                olast_nxt    = (produced_r + kra_pkg::CNT_W'(1)) == n_r;
                produced_nxt = produced_r + kra_pkg::CNT_W'(1);
              end
            end
            kra_pkg::OP_TICK: begin
              if (valid_r[pidx_r]) begin
                if (lease_rd == '0) begin
                  valid_nxt[pidx_r] = 1'b0;
                  active_nxt        = active_r - kra_pkg::CNT_W'(1);
                end else begin
                  lease_wr.we   = 1'b1;
                  lease_wr.addr = pidx_r;
                  lease_wr.data = lease_rd - kra_pkg::LEASE_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
        if (!issuing && !pv_r) begin
          state_nxt = ST_IDLE;
          if (op_r == kra_pkg::OP_REGISTER) begin
            if (match_r) begin
              lease_wr.we   = 1'b1;
              lease_wr.addr = match_idx_r;
              lease_wr.data = lease_cfg_r;
            end else if (free_r) begin
              lease_wr.we           = 1'b1;
              lease_wr.addr         = free_idx_r;
              lease_wr.data         = lease_cfg_r;
              key_wr.we             = 1'b1;
              key_wr.addr           = free_idx_r;
              key_wr.data           = key_r;
              valid_nxt[free_idx_r] = 1'b1;
              active_nxt            = active_r + kra_pkg::CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= kra_pkg::OP_REGISTER;
      key_r       <= '0;
      n_r         <= '0;
      issue_r     <= '0;
      pv_r        <= 1'b0;
      pidx_r      <= '0;
      match_r     <= 1'b0;
      match_idx_r <= '0;
      free_r      <= 1'b0;
      free_idx_r  <= '0;
      produced_r  <= '0;
      valid_r     <= '0;
      active_r    <= '0;
      lease_cfg_r <= kra_pkg::LEASE_W'(kra_pkg::LEASE_RESET);
      strobe_r    <= 1'b0;
      okey_r      <= '0;
      olast_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      key_r       <= key_nxt;
      n_r         <= n_nxt;
      issue_r     <= issue_nxt;
      pv_r        <= pv_nxt;
      pidx_r      <= pidx_nxt;
      match_r     <= match_nxt;
      match_idx_r <= match_idx_nxt;
      free_r      <= free_nxt;
      free_idx_r  <= free_idx_nxt;
      produced_r  <= produced_nxt;
      valid_r     <= valid_nxt;
      active_r    <= active_nxt;
      lease_cfg_r <= lease_cfg_nxt;
      strobe_r    <= strobe_nxt;
      okey_r      <= okey_nxt;
      olast_r     <= olast_nxt;
    end
  end

  assign busy           = state_r != ST_IDLE;
  assign out_strobe     = strobe_r;
  assign out_entry_key  = okey_r;
  assign out_last_entry = olast_r;

  a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r == kra_pkg::CNT_W'($countones(valid_r)))
    else $error("active count differs from the number of valid slots");

  a_produced_bound: assert property (@(posedge clk) disable iff (!rst_n)
    produced_r <= n_r)
    else $error("list answer produced more items than requested");

  a_strobe_from_list: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_nxt |-> (state_r == ST_SCAN) && (op_r == kra_pkg::OP_LIST))
    else $error("result item raised outside a list scan");

  a_key_write_register: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr.we |-> (op_r == kra_pkg::OP_REGISTER) && lease_wr.we && !valid_r[key_wr.addr])
    else $error("key write outside a register item or into a valid slot");

  a_scan_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && !issuing && !pv_r |=> (state_r == ST_IDLE))
    else $error("scan did not return to idle");

endmodule

### rtl/keyed_registry_with_lease_aging_core.sv
// Top level of the keyed registry with lease aging: key and lease memories plus the sequencer.
//
//   Channel  Handshake          Payload
//   input    start, busy        in_opcode, in_source_key, in_list_count
//   result   out_strobe         out_entry_key, out_last_entry
//   config   cfg_we             cfg_data (lease_ticks)
//
// Every item scans all slots, one slot per cycle through the single read port of the
// memories, and holds busy high from acceptance until the scan is done.
// The next item is accepted only once busy has fallen, so items never overlap.
// List results appear at most one per cycle during the scan; each is registered from its slot's read data.
// Reset is synchronous and clears all slots; no clearing pass is needed.
// The receiver cannot stall results; the source is held off by busy.
module keyed_registry_with_lease_aging_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [kra_pkg::KEY_BITS-1:0]  in_source_key,
  input  logic [kra_pkg::WANT_W-1:0]    in_list_count,
  output logic                          out_strobe,
  output logic [kra_pkg::KEY_BITS-1:0]  out_entry_key,
  output logic                          out_last_entry,
  input  logic                          cfg_we,
  input  logic [kra_pkg::LEASE_W-1:0]   cfg_data
);

  logic [kra_pkg::IDX_W-1:0]    rd_addr;
  logic [kra_pkg::KEY_BITS-1:0] key_rd;
  logic [kra_pkg::LEASE_W-1:0]  lease_rd;
  kra_pkg::key_wr_t             key_wr;
  kra_pkg::lease_wr_t           lease_wr;

  kra_ram #(
    .WIDTH (kra_pkg::KEY_BITS),
    .DEPTH (kra_pkg::ENTRIES)
  ) u_key_mem (
    .clk   (clk),
    .we    (key_wr.we),
    .waddr (key_wr.addr),
    .wdata (key_wr.data),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  kra_ram #(
    .WIDTH (kra_pkg::LEASE_W),
    .DEPTH (kra_pkg::ENTRIES)
  ) u_lease_mem (
    .clk   (clk),
    .we    (lease_wr.we),
    .waddr (lease_wr.addr),
    .wdata (lease_wr.data),
    .raddr (rd_addr),
    .rdata (lease_rd)
  );

  kra_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .opcode         (in_opcode),
    .source_key     (in_source_key),
    .list_count     (in_list_count),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .rd_addr        (rd_addr),
    .key_rd         (key_rd),
    .lease_rd       (lease_rd),
    .key_wr         (key_wr),
    .lease_wr       (lease_wr),
    .out_strobe     (out_strobe),
    .out_entry_key  (out_entry_key),
    .out_last_entry (out_last_entry)
  );

endmodule

### tb/kra_shadow_pkg.sv
// Shadow copy of the lease registry that predicts list answers and checks the listed keys.
package kra_shadow_pkg;
  import kra_pkg::*;

  typedef struct {
    logic [KEY_BITS-1:0] key;
    logic                is_last;
  } listed_key_t;

  class registry_shadow;
    bit                  slot_valid [ENTRIES];
    bit [KEY_BITS-1:0]   slot_key [ENTRIES];
    bit [LEASE_W-1:0]    lease_left [ENTRIES];
    int unsigned         active;
    bit [LEASE_W-1:0]    lease_ticks;
    listed_key_t         listed_keys_q[$];
    int unsigned         errors;

    function new();
      foreach (slot_valid[s]) slot_valid[s] = 1'b0;
      active      = 0;
      lease_ticks = LEASE_RESET;
      errors      = 0;
    endfunction

    function void set_lease(bit [LEASE_W-1:0] value);
      lease_ticks = value;
    endfunction

    function int find_key(bit [KEY_BITS-1:0] key);
      for (int s = 0; s < ENTRIES; s++) begin
        if (slot_valid[s] && slot_key[s] == key) return s;
      end
      return -1;
    endfunction

    function int find_free();
      for (int s = 0; s < ENTRIES; s++) begin
        if (!slot_valid[s]) return s;
      end
      return -1;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Applies one accepted item and queues the keys that a list item must return.
    function void note_item(op_t op, bit [KEY_BITS-1:0] key, bit [WANT_W-1:0] want);
      int          s;
      int unsigned n;
      int unsigned made;
      listed_key_t entry;
      case (op)
        OP_REGISTER: begin
          s = find_key(key);
          if (s >= 0) begin
            lease_left[s] = lease_ticks;
          end else begin
            s = find_free();
            if (s >= 0) begin
              slot_valid[s] = 1'b1;
              slot_key[s]   = key;
              lease_left[s] = lease_ticks;
              active++;
            end
          end
        end
        OP_WITHDRAW: begin
          s = find_key(key);
          if (s >= 0) begin
            slot_valid[s] = 1'b0;
            active--;
          end
        end
        OP_LIST: begin
          n    = (want > active) ? active : want;
          made = 0;
          for (s = 0; s < ENTRIES && made < n; s++) begin
            if (slot_valid[s]) begin
              entry.key     = slot_key[s];
              entry.is_last = (made + 1 == n);
              listed_keys_q.push_back(entry);
              made++;
            end
          end
        end
        default: begin
          for (s = 0; s < ENTRIES; s++) begin
            if (slot_valid[s]) begin
              if (lease_left[s] == 0) begin
                slot_valid[s] = 1'b0;
                active--;
              end else begin
                lease_left[s]--;
              end
            end
          end
        end
      endcase
    endfunction

    task check_result(logic [KEY_BITS-1:0] key, logic is_last);
      listed_key_t want;
      if (listed_keys_q.size() == 0) begin
        report($sformatf("unexpected listed key %h last %b", key, is_last));
      end else begin
        want = listed_keys_q.pop_front();
        if (key !== want.key)
          report($sformatf("entry_key %h, predicted %h", key, want.key));
        if (is_last !== want.is_last)
          report($sformatf("last_entry %b, predicted %b (key %h)", is_last, want.is_last,
                           want.key));
      end
    endtask

    task flush_leftover();
      listed_key_t want;
      while (listed_keys_q.size() > 0) begin
        want = listed_keys_q.pop_front();
        report($sformatf("listed key %h last %b never arrived", want.key, want.is_last));
      end
    endtask
  endclass

endpackage

### tb/tb_keyed_registry_with_lease_aging_core.sv
// Testbench for the keyed registry with lease aging: directed and random items under lease settings.
module tb_keyed_registry_with_lease_aging_core;
  import kra_pkg::*;
  import kra_shadow_pkg::*;

  localparam int SETTLE_CYCLES = ENTRIES + 6;
  localparam int STALL_LIMIT   = 1000;
  localparam int POOL_SIZE     = 20;
  localparam int PHASE_ITEMS   = 72;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_opcode;
  logic [KEY_BITS-1:0] in_source_key;
  logic [WANT_W-1:0]   in_list_count;
  logic                out_strobe;
  logic [KEY_BITS-1:0] out_entry_key;
  logic                out_last_entry;
  logic                cfg_we;
  logic [LEASE_W-1:0]  cfg_data;

  registry_shadow      shadow;
  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
  int unsigned         stall_count;

  keyed_registry_with_lease_aging_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_source_key  (in_source_key),
    .in_list_count  (in_list_count),
    .out_strobe     (out_strobe),
    .out_entry_key  (out_entry_key),
    .out_last_entry (out_last_entry),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) shadow.check_result(out_entry_key, out_last_entry);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [KEY_BITS-1:0] random_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_BITS-1:0];
  endfunction

  task automatic send_item(op_t op, logic [KEY_BITS-1:0] key, logic [WANT_W-1:0] want);
    start         <= 1'b1;
    in_opcode     <= op;
    in_source_key <= key;
    in_list_count <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.note_item(op, key, want);
  endtask

  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    shadow.flush_leftover();
  endtask

  task automatic write_lease(logic [LEASE_W-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    shadow.set_lease(value);
  endtask

  task automatic run_phase(int unsigned items);
    int unsigned         done;
    int unsigned         burst;
    int unsigned         roll;
    op_t                 op;
    logic [KEY_BITS-1:0] key;
    logic [WANT_W-1:0]   want;
    done = 0;
    while (done < items) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && done < items; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) op = OP_REGISTER;
        else if (roll < 55) op = OP_WITHDRAW;
        else if (roll < 75) op = OP_LIST;
        else op = OP_TICK;
        key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : random_key();
        want = ($urandom_range(0, 99) < 60) ? WANT_W'($urandom_range(0, 17))
                                            : WANT_W'($urandom_range(0, 255));
        send_item(op, key, want);
        done++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
    end
  endtask

  initial begin
    shadow = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) key_pool[k] = random_key();
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_opcode     <= OP_REGISTER;
    in_source_key <= '0;
    in_list_count <= '0;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty list, fill the table, full-table register, re-register, list sizes, withdraws, a tick.
    send_item(OP_LIST, '0, 8'd255);
    for (int k = 0; k < ENTRIES; k++) begin
      send_item(OP_REGISTER, key_pool[k], '0);
      if (k % 4 == 3) pause($urandom_range(1, 3));
    end
    send_item(OP_REGISTER, key_pool[16], '0);
    send_item(OP_REGISTER, key_pool[3], '0);
    send_item(OP_LIST, '0, 8'd255);
    send_item(OP_LIST, '1, 8'd0);
    send_item(OP_LIST, '0, 8'd5);
    send_item(OP_WITHDRAW, key_pool[17], '0);
    send_item(OP_WITHDRAW, key_pool[0], '0);
    send_item(OP_LIST, '0, 8'd16);
    send_item(OP_TICK, '0, '0);
    send_item(OP_REGISTER, key_pool[16], '0);

    write_lease(16'd0);
    run_phase(PHASE_ITEMS);
    write_lease(16'd1);
    run_phase(PHASE_ITEMS);
    write_lease(16'hFFFF);
    run_phase(PHASE_ITEMS);
    write_lease(16'd2);
    run_phase(PHASE_ITEMS);
    write_lease(LEASE_W'($urandom_range(3, 8)));
    run_phase(PHASE_ITEMS);
    write_lease(16'd30);
    run_phase(PHASE_ITEMS);

    drain();
    if (shadow.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### keyed_registry_with_lease_aging_core.f
rtl/kra_pkg.sv
rtl/kra_ram.sv
rtl/kra_seq.sv
rtl/keyed_registry_with_lease_aging_core.sv
tb/kra_shadow_pkg.sv
tb/tb_keyed_registry_with_lease_aging_core.sv
